// ----- rtl/iosh_pkg.sv -----
// Package for the inside-out shuffle engine: sizes, result codes and the
// store write request type. Used by every file of the block.
`default_nettype none

package iosh_pkg;

	// Largest permutation the store can hold, and the widths that follow.
	localparam int MAX_LENGTH = 256;
	localparam int ADDR_W     = $clog2(MAX_LENGTH);
	localparam int VAL_W      = 9;
	localparam int LEN_W      = 9;
	localparam int KIND_W     = 2;
	localparam int PICK_W     = 8;
	localparam int STATUS_W   = 3;

	// Item kinds on the request channel.
	typedef enum logic [KIND_W-1:0] {
		KIND_STEP    = 2'd0,
		KIND_READ    = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	// Result codes on the response channel.
	typedef enum logic [STATUS_W-1:0] {
		ST_STEP     = 3'd0,
		ST_FINAL    = 3'd1,
		ST_RANGE    = 3'd2,
		ST_DONE     = 3'd3,
		ST_READ_OK  = 3'd4,
		ST_READ_BAD = 3'd5
	} status_t;

	// Write request into the permutation store.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  data;
	} mem_wr_t;

endpackage

`default_nettype wire

// ----- rtl/iosh_req_if.sv -----
// Request channel of the shuffle engine: valid/ready with kind and pick.
// Depends on iosh_pkg for the field widths.
`default_nettype none

interface iosh_req_if;
	import iosh_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [PICK_W-1:0] pick;

	modport source (output valid, output kind, output pick, input ready);
	modport sink   (input valid, input kind, input pick, output ready);
endinterface

`default_nettype wire

// ----- rtl/iosh_rsp_if.sv -----
// Response channel of the shuffle engine: valid/ready with status and value.
// Depends on iosh_pkg for the field widths.
`default_nettype none

interface iosh_rsp_if;
	import iosh_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0]    value;

	modport source (output valid, output status, output value, input ready);
	modport sink   (input valid, input status, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/iosh_perm_mem.sv -----
// Permutation store: one write port and one read port, read data registered.
// Depends on iosh_pkg for sizes and the write request type.
`default_nettype none

module iosh_perm_mem
	import iosh_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_wr_t           wr,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic [VAL_W-1:0]       rdata
);

	logic [VAL_W-1:0] mem_q [MAX_LENGTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/inside_out_shuffle_engine.sv -----
// Inside-out shuffle engine: builds a permutation of 1..length one step
// at a time, with the random index supplied from outside.
//
// Channels: req carries kind and pick, rsp carries status and value; both
// transfer when valid and ready are high at a rising edge. Every request
// gives exactly one response. The user must write the length register
// via length_we / length_wdata only while the block is idle (unchecked).
//
// Sequence: a shuffle step goes from its transfer (store read) through
// S_WR_I and S_WR_P (the two store writes) to S_PUT (response load).
// The single write port of the store takes the two writes one after
// another. A read goes from the store read to the response load; restart
// and rejected items go the same way, from their transfer to S_PUT.
// One item is in work at a time; req is ready again as soon as its
// response is loaded, even when that response is still waiting.
//
// Reset clears the step counter and sets length to 256; the store keeps
// its contents, and unwritten entries are never reachable. When the
// receiver stalls, the response is held and the next finished response
// waits in the engine, with req not ready.
`default_nettype none

module inside_out_shuffle_engine
	import iosh_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	iosh_req_if.sink              req,
	iosh_rsp_if.source            rsp,
	input  wire logic             length_we,
	input  wire logic [LEN_W-1:0] length_wdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WR_I,
		S_WR_P,
		S_PUT
	} state_t;

	state_t              state_q;
	logic [LEN_W-1:0]    length_q;
	logic [LEN_W-1:0]    step_count_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [ADDR_W-1:0]   pick_q;
	status_t             status_q;
	logic                rd_ok_q;
	logic                rsp_valid_q;
	status_t             rsp_status_q;
	logic [VAL_W-1:0]    rsp_value_q;

	logic                accept;
	logic [LEN_W-1:0]    eff_len;
	logic [LEN_W-1:0]    pick_ext;
	logic [LEN_W-1:0]    count_next;
	logic                out_free;
	logic [VAL_W-1:0]    rdata;
	mem_wr_t             mem_wr;

	// Length clamped into the supported range.
	always_comb begin
		priority if (length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (length_q > LEN_W'(MAX_LENGTH)) begin
			eff_len = LEN_W'(MAX_LENGTH);
		end else begin
			eff_len = length_q;
		end
	end

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign pick_ext   = LEN_W'(req.pick);
	assign count_next = step_count_q + LEN_W'(1);
	assign out_free   = !rsp_valid_q || rsp.ready;

	// Length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LEN_W'(256);
		end else if (length_we) begin
			length_q <= length_wdata;
		end
	end

	// Store writes: the old entry at pick moves to the new position, then
	// pick receives the new value. When pick equals the new position the
	// second write wins, as it should.
	always_comb begin
		mem_wr = '0;
		unique case (state_q)
			S_WR_I: begin
				mem_wr.we   = 1'b1;
				mem_wr.addr = idx_q;
				mem_wr.data = rdata;
			end
			S_WR_P: begin
				mem_wr.we   = 1'b1;
				mem_wr.addr = pick_q;
				mem_wr.data = VAL_W'(idx_q) + VAL_W'(1);
			end
			default: begin
				mem_wr = '0;
			end
		endcase
	end

	iosh_perm_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.re    (accept),
		.raddr (req.pick),
		.rdata (rdata)
	);

	// Sequencer, step counter and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_count_q <= '0;
			idx_q        <= '0;
			pick_q       <= '0;
			status_q     <= ST_STEP;
			rd_ok_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_STEP;
			rsp_value_q  <= '0;
		end else begin
			// A taken response empties the register unless a new one is loaded now.
			if (rsp_valid_q && rsp.ready && (state_q != S_PUT)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= step_count_q[ADDR_W-1:0];
						pick_q  <= req.pick;
						rd_ok_q <= 1'b0;
						state_q <= S_PUT;
						unique case (req.kind)
							KIND_STEP: begin
								priority if (step_count_q >= eff_len) begin
									status_q <= ST_DONE;
								end else if (pick_ext > step_count_q) begin
									status_q <= ST_RANGE;
								end else begin
									step_count_q <= count_next;
									status_q     <= (count_next == eff_len) ?
										ST_FINAL : ST_STEP;
									state_q      <= S_WR_I;
								end
							end
							KIND_READ: begin
								if (pick_ext < step_count_q) begin
									status_q <= ST_READ_OK;
									rd_ok_q  <= 1'b1;
								end else begin
									status_q <= ST_READ_BAD;
								end
							end
							KIND_RESTART: begin
								step_count_q <= '0;
								status_q     <= ST_STEP;
							end
							default: begin
								status_q <= ST_READ_BAD;
							end
						endcase
					end
				end
				S_WR_I: begin
					state_q <= S_WR_P;
				end
				S_WR_P: begin
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_value_q  <= rd_ok_q ? rdata : '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.value  = rsp_value_q;

endmodule

`default_nettype wire
